// ===== design/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// shared types, constants and byte selection for the servo packet framer
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int QDepth  = 4;
  localparam int PtrW    = $clog2(QDepth);
  localparam int CntW    = $clog2(QDepth + 1);
  localparam int IdxW    = 5;
  localparam int FracW   = 22;
  localparam int ScaleW  = 20;
  localparam int ProdW   = 16 + ScaleW + 1;
  localparam int SumW    = 40;

  localparam logic [ScaleW-1:0] SCALE_MODE0 = 20'd223696;
  localparam logic [ScaleW-1:0] SCALE_MODE1 = 20'd745654;

  localparam logic [IdxW-1:0] IDX_REG_END = 5'd12;
  localparam logic [IdxW-1:0] IDX_LAST    = 5'd18;

  localparam logic [7:0] BYTE_HDR    = 8'hff;
  localparam logic [7:0] BYTE_LEN    = 8'h09;
  localparam logic [7:0] BYTE_INSTR  = 8'h04;
  localparam logic [7:0] BYTE_ADDR   = 8'h2a;
  localparam logic [7:0] BYTE_SPEED  = 8'h32;
  localparam logic [7:0] BYTE_BCAST  = 8'hfe;
  localparam logic [7:0] BYTE_ALEN   = 8'h02;
  localparam logic [7:0] BYTE_ACTION = 8'h05;
  localparam logic [7:0] BYTE_ACHK   = 8'hfa;
  // sum of the fixed bytes of the register-write packet body
  localparam logic [7:0] BYTE_FIXSUM = 8'h69;

  typedef struct packed {
    logic       mode;
    logic [7:0] servo_id;
    logic [7:0] pos_hi;
    logic [7:0] pos_lo;
    logic [7:0] checksum;
  } spf_entry_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            empty;
  } spf_qstat_t;

  function automatic logic [7:0] frame_byte(input logic [IdxW-1:0] idx,
                                            input spf_entry_t e);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      5'd0, 5'd1, 5'd13, 5'd14: b = BYTE_HDR;
      5'd2:  b = e.servo_id;
      5'd3:  b = BYTE_LEN;
      5'd4:  b = BYTE_INSTR;
      5'd5:  b = BYTE_ADDR;
      5'd6:  b = e.mode ? e.pos_lo : e.pos_hi;
      5'd7:  b = e.mode ? e.pos_hi : e.pos_lo;
      5'd8, 5'd9: b = 8'h00;
      5'd10: b = e.mode ? BYTE_SPEED : 8'h00;
      5'd11: b = e.mode ? 8'h00 : BYTE_SPEED;
      5'd12: b = e.checksum;
      5'd15: b = BYTE_BCAST;
      5'd16: b = BYTE_ALEN;
      5'd17: b = BYTE_ACTION;
      5'd18: b = BYTE_ACHK;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== design/spf_front.sv =====
// ----------------------------------------------------------------------------
// spf_front
// accepts commands, computes the position and checksum in two stages
// ----------------------------------------------------------------------------
module spf_front
  import spf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mode,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_servo_id,
  input  logic signed [15:0] in_angle,
  input  logic signed [15:0] in_position_offset,
  input  spf_qstat_t         qstat,
  output logic               entry_valid,
  output spf_entry_t         entry
);

  logic                     s1_v_r;
  logic                     s2_v_r;
  logic signed [ProdW-1:0]  prod_r;
  logic signed [15:0]       off_r;
  logic [7:0]               id1_r;
  logic                     mode1_r;
  logic signed [SumW-1:0]   sum_r;
  logic [7:0]               id2_r;
  logic                     mode2_r;

  logic [CntW-1:0]          used;
  logic                     accept;
  logic signed [ScaleW:0]   scale;
  logic signed [SumW-1:0]   sum_nxt;
  logic [15:0]              pos;
  logic                     round_up;

  // credits: queue entries plus transactions still in the pipeline
  assign used     = qstat.count + CntW'(s1_v_r) + CntW'(s2_v_r);
  assign in_ready = (used < CntW'(QDepth));
  assign accept   = in_valid && in_ready;

  assign scale = mode ? $signed({1'b0, SCALE_MODE1}) : $signed({1'b0, SCALE_MODE0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r  <= ProdW'(in_angle * scale);
      off_r   <= in_position_offset;
      id1_r   <= in_servo_id;
      mode1_r <= mode;
    end
    sum_r   <= sum_nxt;
    id2_r   <= id1_r;
    mode2_r <= mode1_r;
  end

  assign sum_nxt = SumW'(prod_r) + (SumW'(off_r) <<< FracW);

  // truncate toward zero: round the floor up for inexact negatives
  assign round_up = sum_r[SumW-1] && (|sum_r[FracW-1:0]);
  assign pos      = sum_r[FracW+15:FracW] + 16'(round_up);

  assign entry_valid    = s2_v_r;
  assign entry.mode     = mode2_r;
  assign entry.servo_id = id2_r;
  assign entry.pos_hi   = pos[15:8];
  assign entry.pos_lo   = pos[7:0];
  assign entry.checksum = ~(id2_r + pos[15:8] + pos[7:0] + BYTE_FIXSUM);

endmodule

// ===== design/spf_queue.sv =====
// ----------------------------------------------------------------------------
// spf_queue
// short command queue between the front and the byte sequencer
// ----------------------------------------------------------------------------
module spf_queue
  import spf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  spf_entry_t push_data,
  input  logic       pop,
  output spf_entry_t head,
  output spf_qstat_t qstat
);

  spf_entry_t      entries_r [QDepth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;

  assign count_nxt   = count_r + CntW'(push) - CntW'(pop);
  assign qstat.count = count_r;
  assign qstat.empty = (count_r == '0);
  assign head        = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_data;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CntW'(QDepth)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue pop while empty");
`endif

endmodule

// ===== design/spf_back.sv =====
// ----------------------------------------------------------------------------
// spf_back
// byte sequencer: walks the 19 bytes of both packets into an output register
// ----------------------------------------------------------------------------
module spf_back
  import spf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  spf_entry_t head,
  input  spf_qstat_t qstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_packet_end,
  output logic       out_last
);

  logic [IdxW-1:0] idx_r;
  logic [IdxW-1:0] idx_nxt;
  logic            out_valid_r;
  logic [7:0]      tx_byte_r;
  logic            packet_end_r;
  logic            last_r;
  logic            advance;
  logic            load;

  assign advance = !out_valid_r || out_ready;
  assign load    = advance && !qstat.empty;
  assign pop     = load && (idx_r == IDX_LAST);
  assign idx_nxt = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (advance) begin
      out_valid_r <= !qstat.empty;
      if (load) idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte_r    <= frame_byte(idx_r, head);
      packet_end_r <= (idx_r == IDX_REG_END) || (idx_r == IDX_LAST);
      last_r       <= (idx_r == IDX_LAST);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tx_byte    = tx_byte_r;
  assign out_packet_end = packet_end_r;
  assign out_last       = last_r;

`ifndef ASSERT_OFF
  a_last_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> packet_end_r)
    else $error("last byte without packet end");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("byte index out of range");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == '0))
    else $error("byte index did not wrap after last byte");
`endif

endmodule

// ===== design/servo_position_packet_framer_unit.sv =====
// a command passes the front stages (product, sum) and the queue before its first byte is registered in the output
// throughput: 19 result transactions per command, one per cycle while out_ready holds,
//   set by the single-byte output of the sequencer
// a 4-entry queue lets new commands be taken while bytes are still going out
// reset: synchronous active low, clears the mode register to 0, the queue
//   and all valid flags; no clearing pass
// ----------------------------------------------------------------------------
// servo_position_packet_framer_unit
// frames servo commands into register-write and broadcast action packets
// ----------------------------------------------------------------------------
module servo_position_packet_framer_unit
  import spf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_servo_id,
  input  logic signed [15:0] in_angle,
  input  logic signed [15:0] in_position_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_tx_byte,
  output logic               out_packet_end,
  output logic               out_last
);

  logic       servo_mode_r;
  logic       entry_valid;
  spf_entry_t entry;
  spf_entry_t head;
  spf_qstat_t qstat;
  logic       pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_mode_r <= 1'b0;
    end else if (cfg_we) begin
      servo_mode_r <= cfg_wdata;
    end
  end

  spf_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .mode               (servo_mode_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_servo_id        (in_servo_id),
    .in_angle           (in_angle),
    .in_position_offset (in_position_offset),
    .qstat              (qstat),
    .entry_valid        (entry_valid),
    .entry              (entry)
  );

  spf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (entry_valid),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  spf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .qstat          (qstat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tx_byte    (out_tx_byte),
    .out_packet_end (out_packet_end),
    .out_last       (out_last)
  );

endmodule

// ===== bench/servo_position_packet_framer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// servo_position_packet_framer_unit_tb
// drives servo commands through the framer under random idling on both sides,
// predicts the register-write and action packet bytes for each command and
// checks every transmitted byte with its packet markers
// ----------------------------------------------------------------------------
module servo_position_packet_framer_unit_tb;
  import spf_pkg::*;

  localparam longint ScaleCoarseQ16 = 223696;
  localparam longint ScaleFineQ16   = 745654;
  localparam int     PosFracBits    = 22;
  localparam int     FrameBytes     = 19;
  localparam int     RegEndIdx      = 12;
  localparam int     DirectedCount  = 12;
  localparam int     RandomPhases   = 8;
  localparam int     PhaseCmds      = 51;
  localparam int     StuckLimit     = 5000;
  localparam int     DrainCycles    = 40;

  typedef struct packed {
    logic [7:0]  servo_id;
    logic [15:0] angle;
    logic [15:0] position_offset;
  } servo_cmd_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       packet_end;
    logic       last;
  } bus_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_servo_id = '0;
  logic signed [15:0] in_angle = '0;
  logic signed [15:0] in_position_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_tx_byte;
  logic out_packet_end;
  logic out_last;

  servo_cmd_t cmd_q[$];
  bus_byte_t  tx_frame_q[$];
  logic       mode_shadow = 1'b0;
  logic       in_idle_on = 1'b1;
  logic       out_idle_on = 1'b1;
  int         in_gap_left = 0;
  int         out_stall_left = 0;
  int         stuck_cycles = 0;
  int         fail_count = 0;

  servo_position_packet_framer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_servo_id       (in_servo_id),
    .in_angle          (in_angle),
    .in_position_offset(in_position_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tx_byte       (out_tx_byte),
    .out_packet_end    (out_packet_end),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(input logic enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // position = trunc(angle * scale + offset * 2^22) >> 22, kept to 16 bits
  function automatic void frame_servo_command(input servo_cmd_t cmd, input logic mode);
    longint    scaled;
    longint    whole;
    logic [15:0] pos;
    logic [7:0]  pkt[FrameBytes];
    logic [7:0]  chk;
    bus_byte_t   b;
    scaled = longint'($signed(cmd.angle)) * (mode ? ScaleFineQ16 : ScaleCoarseQ16)
           + (longint'($signed(cmd.position_offset)) <<< PosFracBits);
    if (scaled < 0) whole = -((-scaled) >> PosFracBits);
    else whole = scaled >> PosFracBits;
    pos = whole[15:0];
    pkt[0]  = BYTE_HDR;
    pkt[1]  = BYTE_HDR;
    pkt[2]  = cmd.servo_id;
    pkt[3]  = BYTE_LEN;
    pkt[4]  = BYTE_INSTR;
    pkt[5]  = BYTE_ADDR;
    pkt[6]  = mode ? pos[7:0] : pos[15:8];
    pkt[7]  = mode ? pos[15:8] : pos[7:0];
    pkt[8]  = 8'h00;
    pkt[9]  = 8'h00;
    pkt[10] = mode ? BYTE_SPEED : 8'h00;
    pkt[11] = mode ? 8'h00 : BYTE_SPEED;
    chk = 8'h00;
    for (int i = 2; i < RegEndIdx; i++) chk = chk + pkt[i];
    pkt[12] = ~chk;
    pkt[13] = BYTE_HDR;
    pkt[14] = BYTE_HDR;
    pkt[15] = BYTE_BCAST;
    pkt[16] = BYTE_ALEN;
    pkt[17] = BYTE_ACTION;
    pkt[18] = BYTE_ACHK;
    for (int i = 0; i < FrameBytes; i++) begin
      b.tx_byte    = pkt[i];
      b.packet_end = (i == RegEndIdx) || (i == FrameBytes - 1);
      b.last       = (i == FrameBytes - 1);
      tx_frame_q.push_back(b);
    end
  endfunction

  // command driver
  always @(posedge clk) begin
    servo_cmd_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap_left <= 0;
    end else begin
      if (in_valid && in_ready)
        frame_servo_command({in_servo_id, in_angle, in_position_offset}, mode_shadow);
      if (!in_valid || in_ready) begin
        if (in_gap_left != 0) begin
          in_valid <= 1'b0;
          in_gap_left <= in_gap_left - 1;
        end else if (cmd_q.size() != 0) begin
          cmd = cmd_q.pop_front();
          in_servo_id <= cmd.servo_id;
          in_angle <= cmd.angle;
          in_position_offset <= cmd.position_offset;
          in_valid <= 1'b1;
          in_gap_left <= pick_gap(in_idle_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // byte monitor
  always @(posedge clk) begin
    bus_byte_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (tx_frame_q.size() == 0) begin
          $error("unexpected byte transaction: tx_byte %h", out_tx_byte);
          fail_count++;
        end else begin
          want = tx_frame_q.pop_front();
          if (out_tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %h, got %h", want.tx_byte, out_tx_byte);
            fail_count++;
          end
          if (out_packet_end !== want.packet_end) begin
            $error("packet_end: expected %b, got %b", want.packet_end, out_packet_end);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (out_stall_left != 0) begin
        out_ready <= 1'b0;
        out_stall_left <= out_stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall_left <= pick_gap(out_idle_on);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("servo_position_packet_framer_unit_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_valid || tx_frame_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_servo_mode(input logic m);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    mode_shadow = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_cmd(input logic [7:0] id, input logic [15:0] ang,
                         input logic [15:0] off);
    servo_cmd_t c;
    c.servo_id        = id;
    c.angle           = ang;
    c.position_offset = off;
    cmd_q.push_back(c);
  endtask

  initial begin
    servo_cmd_t directed[DirectedCount];
    logic [15:0] ang;
    logic [7:0]  id;
    directed = '{
      '{8'd0,   16'sd0,      16'sd0},
      '{8'd253, 16'sd23040,  16'sd0},
      '{8'd254, -16'sd23040, 16'sd0},
      '{8'd255, 16'sd32767,  16'sd32767},
      '{8'h5a,  16'h8000,    16'h8000},
      '{8'ha5,  -16'sd1,     16'sd0},
      '{8'd1,   16'sd1,      -16'sd1},
      '{8'd2,   16'sd23040,  16'sd32767},
      '{8'd3,   -16'sd23040, 16'h8000},
      '{8'd4,   16'sd0,      -16'sd1},
      '{8'd5,   16'sd0,      16'sd32767},
      '{8'd6,   16'sd64,     16'sd0}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed commands in both modes
    for (int m = 0; m < 2; m++) begin
      write_servo_mode(m[0]);
      for (int i = 0; i < DirectedCount; i++) cmd_q.push_back(directed[i]);
    end

    // random phases, with every combination of idling on the two sides
    for (int p = 0; p < RandomPhases; p++) begin
      write_servo_mode(1'($urandom_range(0, 1)));
      in_idle_on = p[0];
      out_idle_on = p[1];
      for (int i = 0; i < PhaseCmds; i++) begin
        if ($urandom_range(0, 3) != 0) ang = 16'($urandom_range(0, 46080) - 23040);
        else ang = 16'($urandom());
        if ($urandom_range(0, 7) != 0) id = 8'($urandom_range(0, 253));
        else id = 8'($urandom());
        add_cmd(id, ang, 16'($urandom()));
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && tx_frame_q.size() == 0) begin
      $display("servo_position_packet_framer_unit_tb OK");
    end else begin
      $display("servo_position_packet_framer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
